>>> src/mlqs_pkg.sv
// Shared definitions for the multilevel queue slot scheduler.
// Holds sizing constants, payload structs, status codes and address helpers.
// No dependencies; every other source file imports this package.
package mlqs_pkg;

    localparam int NUM_LEVELS  = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;

    localparam int LVL_W      = $clog2(NUM_LEVELS);
    localparam int LVL_SUM_W  = LVL_W + 1;
    localparam int SLOT_W     = $clog2(NUM_LEVELS + 1);
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int FIFO_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_GET = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] proc_id;
        logic [3:0] priority_req;
    } in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_id;
        logic [3:0] granted_level;
    } out_t;

    // Per-level FIFO bookkeeping kept in the metadata memory.
    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
        logic [CNT_W-1:0] count;
    } meta_t;

    // Decision of the level picker for a request.
    typedef struct packed {
        logic             any;
        logic [LVL_W-1:0] level;
        logic             fresh;
    } pick_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_META  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        logic [PTR_W-1:0] nxt;
        if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + PTR_W'(1);
        end
        return nxt;
    endfunction

    function automatic logic [FIFO_AW-1:0] fifo_addr(input logic [LVL_W-1:0] lvl,
                                                     input logic [PTR_W-1:0] ptr);
        return FIFO_AW'(lvl * QUEUE_DEPTH) + FIFO_AW'(ptr);
    endfunction

endpackage

>>> src/multilevel_queue_slot_scheduler_unit.sv
// Top level of the multilevel queue slot scheduler: control sequencer,
// level picker and the two memories. Depends on mlqs_pkg, mlqs_meta_ram,
// mlqs_id_ram and mlqs_level_pick.
//
//   Channel | Ports                       | Payload
//   --------+-----------------------------+---------------------------------
//   input   | s_valid, s_ready, s_data    | mode, proc_id, priority_req
//   result  | m_valid, m_ready, m_data    | status, granted_id, granted_level
//
// One transaction at a time: an add passes through the metadata and response
// states, and a request through the metadata, id fetch and response states,
// for the metadata read followed by the id memory read.
// A request with every level empty goes straight to the response state.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A new transaction is taken while a finished result waits in the output
// register; a stalled output holds the sequencer in its response state.
module multilevel_queue_slot_scheduler_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mlqs_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mlqs_pkg::out_t m_data
);
    import mlqs_pkg::*;

    state_t                state_reg, state_next;
    in_t                   item_reg, item_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    out_t                  res_reg, res_next;
    logic [LVL_W-1:0]      cur_reg, cur_next;
    logic [SLOT_W-1:0]     slots_reg, slots_next;
    logic [NUM_LEVELS-1:0] nonempty_reg, nonempty_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    pick_t                 pick;
    logic                  accept;
    logic                  out_free;

    logic [LVL_W-1:0]      meta_rd_addr;
    meta_t                 meta_rd;
    logic                  meta_wr_en;
    meta_t                 meta_wr;

    logic [FIFO_AW-1:0]    id_rd_addr;
    logic [ID_BITS-1:0]    id_rd;
    logic                  id_wr_en;
    logic [FIFO_AW-1:0]    id_wr_addr;

    mlqs_level_pick u_pick (
        .cur_level  (cur_reg),
        .slots_used (slots_reg),
        .nonempty   (nonempty_reg),
        .pick       (pick)
    );

    mlqs_meta_ram u_meta (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_addr (meta_rd_addr),
        .rd_data (meta_rd),
        .wr_en   (meta_wr_en),
        .wr_addr (lvl_reg),
        .wr_data (meta_wr)
    );

    mlqs_id_ram u_ids (
        .aclk    (aclk),
        .rd_addr (id_rd_addr),
        .rd_data (id_rd),
        .wr_en   (id_wr_en),
        .wr_addr (id_wr_addr),
        .wr_data (ID_BITS'(item_reg.proc_id))
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign meta_rd_addr = (state_reg == ST_IDLE) ?
                          ((s_data.mode == MODE_ADD) ? LVL_W'(s_data.priority_req)
                                                     : pick.level)
                          : lvl_reg;
    assign id_rd_addr   = fifo_addr(lvl_reg, meta_rd.head);
    assign id_wr_addr   = fifo_addr(lvl_reg, meta_rd.tail);

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        lvl_next      = lvl_reg;
        res_next      = res_reg;
        cur_next      = cur_reg;
        slots_next    = slots_reg;
        nonempty_next = nonempty_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        meta_wr_en    = 1'b0;
        meta_wr       = meta_rd;
        id_wr_en      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    item_next = s_data;
                    res_next  = '0;
                    if (s_data.mode == MODE_ADD) begin
                        lvl_next   = LVL_W'(s_data.priority_req);
                        state_next = ST_META;
                    end else if (!pick.any) begin
                        res_next.status = ST_NONE;
                        state_next      = ST_RESP;
                    end else begin
                        lvl_next   = pick.level;
                        cur_next   = pick.level;
                        slots_next = pick.fresh ? SLOT_W'(1) : slots_reg + SLOT_W'(1);
                        state_next = ST_META;
                    end
                end
            end
            ST_META: begin
                if (item_reg.mode == MODE_ADD) begin
                    if ((int'(item_reg.priority_req) >= NUM_LEVELS) ||
                        (meta_rd.count >= CNT_W'(QUEUE_DEPTH))) begin
                        res_next.status = ST_FULL;
                    end else begin
                        id_wr_en               = 1'b1;
                        meta_wr_en             = 1'b1;
                        meta_wr.tail           = ptr_inc(meta_rd.tail);
                        meta_wr.count          = meta_rd.count + CNT_W'(1);
                        nonempty_next[lvl_reg] = 1'b1;
                    end
                    state_next = ST_RESP;
                end else begin
                    meta_wr_en             = 1'b1;
                    meta_wr.head           = ptr_inc(meta_rd.head);
                    meta_wr.count          = meta_rd.count - CNT_W'(1);
                    nonempty_next[lvl_reg] = (meta_rd.count != CNT_W'(1));
                    state_next             = ST_FETCH;
                end
            end
            ST_FETCH: begin
                res_next.status        = ST_OK;
                res_next.granted_id    = 8'(id_rd);
                res_next.granted_level = 4'(lvl_reg);
                state_next             = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cur_reg      <= '0;
            slots_reg    <= '0;
            nonempty_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_reg      <= cur_next;
            slots_reg    <= slots_next;
            nonempty_reg <= nonempty_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        lvl_reg    <= lvl_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A new result appears only when the sequencer leaves its response state.
    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside the response state");

    // A granted level always holds at least one id when it is chosen.
    a_grant_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.mode == MODE_GET && pick.any) |-> nonempty_reg[pick.level])
        else $error("request granted from an empty level");

    // The slot count never passes the weight of the current level.
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(slots_reg) <= (NUM_LEVELS - int'(cur_reg)))
        else $error("slot count exceeds the level weight");

endmodule

>>> src/mlqs_meta_ram.sv
// Metadata memory: head, tail and count of every level FIFO.
// One read and one write port, registered read; depends on mlqs_pkg.
// Entries never written since reset read as zero through per-entry valid bits.
module mlqs_meta_ram (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [mlqs_pkg::LVL_W-1:0] rd_addr,
    output mlqs_pkg::meta_t           rd_data,
    input  logic                      wr_en,
    input  logic [mlqs_pkg::LVL_W-1:0] wr_addr,
    input  mlqs_pkg::meta_t           wr_data
);
    import mlqs_pkg::*;

    meta_t                 mem [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] valid_reg;
    meta_t                 rd_mem_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_mem_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : '0;

endmodule

>>> src/mlqs_id_ram.sv
// Process id store: all level FIFOs packed into one memory, level-major.
// One read and one write port, registered read; depends on mlqs_pkg.
module mlqs_id_ram (
    input  logic                        aclk,
    input  logic [mlqs_pkg::FIFO_AW-1:0] rd_addr,
    output logic [mlqs_pkg::ID_BITS-1:0] rd_data,
    input  logic                        wr_en,
    input  logic [mlqs_pkg::FIFO_AW-1:0] wr_addr,
    input  logic [mlqs_pkg::ID_BITS-1:0] wr_data
);
    import mlqs_pkg::*;

    logic [ID_BITS-1:0] mem [FIFO_DEPTH];
    logic [ID_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/mlqs_level_pick.sv
// Level picker: decides which level serves the next request.
// Stays on the current level while it has ids and slots left, otherwise
// finds the next non-empty level in rotation order; depends on mlqs_pkg.
module mlqs_level_pick (
    input  logic [mlqs_pkg::LVL_W-1:0]  cur_level,
    input  logic [mlqs_pkg::SLOT_W-1:0] slots_used,
    input  logic [mlqs_pkg::NUM_LEVELS-1:0] nonempty,
    output mlqs_pkg::pick_t            pick
);
    import mlqs_pkg::*;

    logic                 stay;
    logic [LVL_W-1:0]     next_lvl;
    logic [LVL_SUM_W-1:0] lvl_sum;

    assign stay = nonempty[cur_level] &&
                  (slots_used < (SLOT_W'(NUM_LEVELS) - SLOT_W'(cur_level)));

    // Scan from the farthest level back to the nearest so the nearest wins.
    // When no other level has ids, the scan wraps around to the current level.
    always_comb begin
        next_lvl = cur_level;
        lvl_sum  = '0;
        for (int i = NUM_LEVELS; i >= 1; i--) begin
            lvl_sum = LVL_SUM_W'(cur_level) + LVL_SUM_W'(i);
            if (lvl_sum >= LVL_SUM_W'(NUM_LEVELS)) begin
                lvl_sum = lvl_sum - LVL_SUM_W'(NUM_LEVELS);
            end
            if (nonempty[LVL_W'(lvl_sum)]) begin
                next_lvl = LVL_W'(lvl_sum);
            end
        end
    end

    assign pick.any   = |nonempty;
    assign pick.level = stay ? cur_level : next_lvl;
    assign pick.fresh = !stay;

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for multilevel_queue_slot_scheduler_unit.
// Predicts each result with its own model of the level FIFOs and the weighted rotation.
// Depends on mlqs_pkg and the scheduler RTL only.
module tb;
    import mlqs_pkg::*;

    localparam int RANDOM_ITEMS = 1500;
    localparam int WIND_DOWN    = 150;

    typedef struct {
        in_t txn;
        bit  hold;
    } queued_txn_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    queued_txn_t pending_txns[$];
    out_t        expected_results[$];
    int          error_count = 0;
    int          accepted_count = 0;
    int          received_count = 0;
    int          send_gap = 0;
    int          send_gap_pct = 10;
    int          stall_left = 0;
    int          stall_pct = 10;

    // Scheduler state as seen by the predictor.
    logic [7:0]       lvl_ids [NUM_LEVELS][QUEUE_DEPTH];
    logic [PTR_W-1:0] lvl_head [NUM_LEVELS];
    logic [PTR_W-1:0] lvl_tail [NUM_LEVELS];
    logic [CNT_W-1:0] lvl_fill [NUM_LEVELS];
    logic [LVL_W-1:0] cur_lvl;
    logic [SLOT_W:0]  grants_in_turn;

    multilevel_queue_slot_scheduler_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic out_t schedule_next(input in_t txn);
        out_t       res;
        logic       any_ready;
        logic       granted;
        int         lvl;
        logic [7:0] pid;
        res = '0;
        res.status = ST_OK;
        pid = txn.proc_id & 8'((64'd1 << ID_BITS) - 1);
        lvl = int'(txn.priority_req);
        if (txn.mode == MODE_ADD) begin
            if (lvl >= NUM_LEVELS || int'(lvl_fill[lvl]) >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                lvl_ids[lvl][lvl_tail[lvl]] = pid;
                lvl_tail[lvl] = (int'(lvl_tail[lvl]) == QUEUE_DEPTH - 1) ? '0
                                                                         : lvl_tail[lvl] + 1'b1;
                lvl_fill[lvl] = lvl_fill[lvl] + 1'b1;
            end
        end else begin
            any_ready = 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (lvl_fill[l] != 0) begin
                    any_ready = 1'b1;
                end
            end
            if (!any_ready) begin
                res.status = ST_NONE;
            end else begin
                granted = 1'b0;
                // Stay on the current level until it runs dry or uses up its
                // share of consecutive grants, then move to the next one.
                for (int guard = 0; guard < 2 * NUM_LEVELS + 2 && !granted; guard++) begin
                    lvl = int'(cur_lvl);
                    if (lvl_fill[lvl] != 0 && int'(grants_in_turn) < NUM_LEVELS - lvl) begin
                        res.granted_id    = lvl_ids[lvl][lvl_head[lvl]];
                        res.granted_level = 4'(lvl);
                        lvl_head[lvl] = (int'(lvl_head[lvl]) == QUEUE_DEPTH - 1) ? '0
                                                                                 : lvl_head[lvl] + 1'b1;
                        lvl_fill[lvl] = lvl_fill[lvl] - 1'b1;
                        grants_in_turn = grants_in_turn + 1'b1;
                        granted = 1'b1;
                    end else begin
                        grants_in_turn = '0;
                        cur_lvl = (lvl == NUM_LEVELS - 1) ? '0 : LVL_W'(lvl + 1);
                    end
                end
                if (!granted) begin
                    res = '0;
                    res.status = ST_NONE;
                end
            end
        end
        return res;
    endfunction

    task automatic queue_txn(input logic mode, input logic [7:0] pid,
                             input logic [3:0] lvl, input bit hold);
        queued_txn_t q;
        q.txn.mode         = mode;
        q.txn.proc_id      = pid;
        q.txn.priority_req = lvl;
        q.hold             = hold;
        pending_txns.push_back(q);
    endtask

    // Driver: offers queued transactions and predicts each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(schedule_next(s_data));
                accepted_count++;
                if (accepted_count % 100 == 0) begin
                    case ($urandom_range(0, 2))
                        0: send_gap_pct = 0;
                        1: send_gap_pct = 15;
                        default: send_gap_pct = 45;
                    endcase
                end
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_txns.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_txns[0].hold && expected_results.size() != 0) begin
                    s_valid <= 1'b0;
                end else if (pending_txns.size() > WIND_DOWN &&
                             $urandom_range(0, 99) < send_gap_pct) begin
                    send_gap = $urandom_range(1, 14) - 1;
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= pending_txns[0].txn;
                    pending_txns.pop_front();
                end
            end
        end
    end

    // Monitor: checks every accepted result against the oldest prediction.
    always @(posedge aclk) begin
        out_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                received_count++;
                if (received_count % 100 == 0) begin
                    case ($urandom_range(0, 2))
                        0: stall_pct = 0;
                        1: stall_pct = 15;
                        default: stall_pct = 45;
                    endcase
                end
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, m_data);
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_data.status !== exp_res.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_res.status, m_data.status);
                        error_count++;
                    end
                    if (m_data.granted_id !== exp_res.granted_id) begin
                        $display("%0t: granted_id expected %0d actual %0d",
                                 $time, exp_res.granted_id, m_data.granted_id);
                        error_count++;
                    end
                    if (m_data.granted_level !== exp_res.granted_level) begin
                        $display("%0t: granted_level expected %0d actual %0d",
                                 $time, exp_res.granted_level, m_data.granted_level);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (pending_txns.size() > WIND_DOWN &&
                         $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int         queued;
        int         seg_len;
        logic [3:0] base_lvl;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            lvl_head[l] = '0;
            lvl_tail[l] = '0;
            lvl_fill[l] = '0;
            for (int d = 0; d < QUEUE_DEPTH; d++) begin
                lvl_ids[l][d] = '0;
            end
        end
        cur_lvl        = '0;
        grants_in_turn = '0;

        // Directed: request with nothing queued, the id and level extremes,
        // then one level filled past its depth and partly drained.
        queue_txn(MODE_GET, 8'hA5, 4'd9, 1'b0);
        queue_txn(MODE_ADD, 8'hFF, 4'd15, 1'b0);
        queue_txn(MODE_ADD, 8'h00, 4'd0, 1'b0);
        queue_txn(MODE_GET, 8'h5A, 4'd3, 1'b0);
        queue_txn(MODE_GET, 8'hFF, 4'd15, 1'b0);
        queue_txn(MODE_GET, 8'h00, 4'd0, 1'b0);
        for (int i = 0; i < QUEUE_DEPTH + 1; i++) begin
            queue_txn(MODE_ADD, 8'(8'hA0 + i), 4'd7, 1'b0);
        end
        queue_txn(MODE_GET, 8'h00, 4'd0, 1'b0);
        queue_txn(MODE_GET, 8'h00, 4'd0, 1'b0);

        // Random: fill bursts, drain bursts, mixed noise and all-level sweeps.
        queued = 0;
        while (queued < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    base_lvl = 4'($urandom_range(0, 15));
                    seg_len  = $urandom_range(1, 20);
                    for (int i = 0; i < seg_len; i++) begin
                        queue_txn(MODE_ADD, 8'($urandom_range(0, 255)),
                                  ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                              : base_lvl,
                                  queued == 0 || queued == RANDOM_ITEMS / 2);
                        queued++;
                    end
                end
                4, 5, 6: begin
                    seg_len = $urandom_range(1, 24);
                    for (int i = 0; i < seg_len; i++) begin
                        queue_txn(MODE_GET, 8'($urandom_range(0, 255)),
                                  4'($urandom_range(0, 15)),
                                  queued == 0 || queued == RANDOM_ITEMS / 2);
                        queued++;
                    end
                end
                7, 8: begin
                    seg_len = $urandom_range(1, 16);
                    for (int i = 0; i < seg_len; i++) begin
                        queue_txn(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                  4'($urandom_range(0, 15)),
                                  queued == 0 || queued == RANDOM_ITEMS / 2);
                        queued++;
                    end
                end
                default: begin
                    for (int l = 0; l < NUM_LEVELS; l++) begin
                        queue_txn(MODE_ADD, 8'($urandom_range(0, 255)), 4'(l),
                                  queued == 0 || queued == RANDOM_ITEMS / 2);
                        queued++;
                    end
                    seg_len = $urandom_range(1, 40);
                    for (int i = 0; i < seg_len; i++) begin
                        queue_txn(MODE_GET, 8'($urandom_range(0, 255)),
                                  4'($urandom_range(0, 15)), 1'b0);
                        queued++;
                    end
                end
            endcase
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_txns.size() != 0 || s_valid) begin
            @(posedge aclk);
        end
        while (expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("PASS multilevel_queue_slot_scheduler_unit");
        end else begin
            $display("FAIL multilevel_queue_slot_scheduler_unit");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL multilevel_queue_slot_scheduler_unit");
        $finish;
    end

endmodule
